>>> src/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types, constants and control codes of the pilot signal window
// qualifier.
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int SAMPLE_W   = 16;
    localparam int MISFIT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [MISFIT_W-1:0]   misfit_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t CFG_PILOT_MAX_DEV = 2'd0;
    localparam cfg_idx_t CFG_PROX_MAX_DEV  = 2'd1;
    localparam cfg_idx_t CFG_MAX_MISFITS   = 2'd2;

    localparam sample_t PILOT_MAX_DEV_RST = 16'd100;
    localparam sample_t PROX_MAX_DEV_RST  = 16'd100;
    localparam misfit_t MAX_MISFITS_RST   = 7'd2;

    // One entry of the three windows, as held by one cell
    typedef struct packed {
        sample_t hi;
        sample_t lo;
        sample_t px;
    } trio_t;

    // Per-cycle commands from the sequencer to each lane
    typedef struct packed {
        logic clear;
        logic accumulate;
        logic load;
        logic count;
    } lane_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LOAD,
        ST_COUNT,
        ST_DONE
    } state_t;

endpackage

>>> src/psw_if.sv
// ----------------------------------------------------------------------------
// psw_if
// Handshake channels of the pilot signal window qualifier: sample input,
// result output and register write.
// ----------------------------------------------------------------------------
interface psw_in_if
    import psw_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t pilot_high_sample;
    sample_t pilot_low_sample;
    sample_t proximity_sample;

    modport source (output valid, pilot_high_sample, pilot_low_sample, proximity_sample,
                    input ready);
    modport sink   (input valid, pilot_high_sample, pilot_low_sample, proximity_sample,
                    output ready);
endinterface

interface psw_out_if
    import psw_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t pilot_high_mean;
    sample_t pilot_low_mean;
    sample_t proximity_mean;
    misfit_t pilot_high_misfits;
    misfit_t pilot_low_misfits;
    misfit_t proximity_misfits;
    logic    signal_valid;

    modport source (output valid, pilot_high_mean, pilot_low_mean, proximity_mean,
                    pilot_high_misfits, pilot_low_misfits, proximity_misfits,
                    signal_valid, input ready);
    modport sink   (input valid, pilot_high_mean, pilot_low_mean, proximity_mean,
                    pilot_high_misfits, pilot_low_misfits, proximity_misfits,
                    signal_valid, output ready);
endinterface

interface psw_cfg_if
    import psw_pkg::*;
;
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/psw_cell.sv
// ----------------------------------------------------------------------------
// psw_cell
// One window entry for all three channels. Takes its neighbor's entry when
// the ring moves and holds otherwise.
// ----------------------------------------------------------------------------
module psw_cell
    import psw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  trio_t data_in,
    output trio_t data_out
);

    trio_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= data_in;
        end
    end

    assign data_out = entry_reg;

endmodule

>>> src/psw_lane.sv
// ----------------------------------------------------------------------------
// psw_lane
// Per-channel arithmetic: sums the entries passing the ring tail, scales the
// sum by a fixed reciprocal of the window length to get the mean, then counts
// entries whose distance from the mean exceeds the limit.
// ----------------------------------------------------------------------------
module psw_lane
    import psw_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    input  sample_t    tail,
    input  sample_t    limit,
    output sample_t    mean,
    output misfit_t    misfits
);

    localparam int     LOG_W   = $clog2(WINDOW);
    localparam int     SUM_W   = SAMPLE_W + LOG_W;
    localparam int     SHIFT   = SUM_W + LOG_W;
    localparam int     RECIP_W = SUM_W + 1;
    localparam int     PROD_W  = SUM_W + RECIP_W;
    localparam longint ONE_L   = 1;
    // Rounded-up reciprocal: exact truncated quotient for every SUM_W-bit sum
    localparam longint RECIP_L = ((ONE_L << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic [SUM_W-1:0] sum_reg;
    sample_t          quot_reg;
    misfit_t          cnt_reg;

    logic [PROD_W-1:0] product;
    logic [SAMPLE_W:0] diff_up;
    logic [SAMPLE_W:0] diff_dn;
    sample_t           distance;

    always_comb
    begin
        product  = PROD_W'(sum_reg) * PROD_W'(RECIP);
        diff_up  = {1'b0, tail} - {1'b0, quot_reg};
        diff_dn  = {1'b0, quot_reg} - {1'b0, tail};
        distance = diff_up[SAMPLE_W] ? diff_dn[SAMPLE_W-1:0] : diff_up[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else if (ctrl.accumulate)
            begin
                sum_reg <= sum_reg + SUM_W'(tail);
            end
            else if (ctrl.count && (distance > limit))
            begin
                cnt_reg <= cnt_reg + 7'd1;
            end

            if (ctrl.load)
            begin
                quot_reg <= product[SHIFT +: SAMPLE_W];
            end
        end
    end

    assign mean    = quot_reg;
    assign misfits = cnt_reg;

endmodule

>>> src/pilot_signal_window_qualifier.sv
// ----------------------------------------------------------------------------
// pilot_signal_window_qualifier
// Three sample windows kept in a ring of cells, with truncated means, misfit
// counts and a signal qualification flag per burst.
// ----------------------------------------------------------------------------
// Sequence: after an input transaction the lanes make two passes around the
//   cell ring, with one multiply between them, and the result waits until
//   the output register is free. Input closes during a burst and is taken
//   again as soon as the result sits in the output register.
// Reset: all window entries, write position and the full flag clear; the
//   registers return to 100, 100 and 2.
module pilot_signal_window_qualifier
    import psw_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    psw_in_if.sink    in_ch,
    psw_out_if.source out_ch,
    psw_cfg_if.sink   cfg_ch
);

    localparam int POS_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] LAST_WIN  = CNT_W'(WINDOW - 1);

    // Configuration registers
    sample_t pilot_dev_reg;
    sample_t prox_dev_reg;
    misfit_t max_mis_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pilot_dev_reg <= PILOT_MAX_DEV_RST;
            prox_dev_reg  <= PROX_MAX_DEV_RST;
            max_mis_reg   <= MAX_MISFITS_RST;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_PILOT_MAX_DEV: pilot_dev_reg <= cfg_ch.data;
                CFG_PROX_MAX_DEV:  prox_dev_reg  <= cfg_ch.data;
                CFG_MAX_MISFITS:   max_mis_reg   <= cfg_ch.data[MISFIT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Sequencer
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             full_reg, full_next;
    logic             accept;
    logic             rotate;
    logic             result_load;
    lane_ctrl_t       ctrl;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg + CNT_W'(1);
        pos_next    = pos_reg;
        full_next   = full_reg;
        rotate      = 1'b0;
        result_load = 1'b0;
        ctrl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    ctrl.clear = 1'b1;
                    state_next = ST_SUM;
                    if (pos_reg == LAST_POS)
                    begin
                        pos_next  = '0;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            ST_SUM:
            begin
                rotate          = 1'b1;
                ctrl.accumulate = 1'b1;
                if (step_reg == LAST_WIN)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ctrl.load  = 1'b1;
                step_next  = '0;
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                rotate     = 1'b1;
                ctrl.count = 1'b1;
                if (step_reg == LAST_WIN)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_ch.valid || out_ch.ready)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            pos_reg   <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
            full_reg  <= full_next;
        end
    end

    // Ring of cells: new entry at the head on a transaction, tail feeds the
    // head while the lanes scan
    trio_t ring [WINDOW];
    trio_t head_in;
    trio_t tail;

    assign tail = ring[WINDOW-1];

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            head_in.hi = in_ch.pilot_high_sample;
            head_in.lo = in_ch.pilot_low_sample;
            head_in.px = in_ch.proximity_sample;
        end
        else
        begin
            head_in = tail;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            psw_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (accept || rotate),
                .data_in  ((gi == 0) ? head_in : ring[(gi == 0) ? 0 : gi - 1]),
                .data_out (ring[gi])
            );
        end
    endgenerate

    // Lanes
    sample_t hi_mean, lo_mean, px_mean;
    misfit_t hi_mis, lo_mis, px_mis;

    psw_lane #(.WINDOW(WINDOW)) u_lane_hi (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .tail    (tail.hi),
        .limit   (pilot_dev_reg),
        .mean    (hi_mean),
        .misfits (hi_mis)
    );

    psw_lane #(.WINDOW(WINDOW)) u_lane_lo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .tail    (tail.lo),
        .limit   (pilot_dev_reg),
        .mean    (lo_mean),
        .misfits (lo_mis)
    );

    psw_lane #(.WINDOW(WINDOW)) u_lane_px (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .tail    (tail.px),
        .limit   (prox_dev_reg),
        .mean    (px_mean),
        .misfits (px_mis)
    );

    // Output register
    logic    out_valid_reg;
    sample_t hi_mean_reg, lo_mean_reg, px_mean_reg;
    misfit_t hi_mis_reg, lo_mis_reg, px_mis_reg;
    logic    sig_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            hi_mean_reg   <= hi_mean;
            lo_mean_reg   <= lo_mean;
            px_mean_reg   <= px_mean;
            hi_mis_reg    <= hi_mis;
            lo_mis_reg    <= lo_mis;
            px_mis_reg    <= px_mis;
            sig_valid_reg <= full_reg && (hi_mis <= max_mis_reg) && (lo_mis <= max_mis_reg);
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.pilot_high_mean    = hi_mean_reg;
    assign out_ch.pilot_low_mean     = lo_mean_reg;
    assign out_ch.proximity_mean     = px_mean_reg;
    assign out_ch.pilot_high_misfits = hi_mis_reg;
    assign out_ch.pilot_low_misfits  = lo_mis_reg;
    assign out_ch.proximity_misfits  = px_mis_reg;
    assign out_ch.signal_valid       = sig_valid_reg;

endmodule

>>> src/psw_checker.sv
// ----------------------------------------------------------------------------
// psw_checker
// Port-level checks of the pilot signal window qualifier, bound to the top.
// ----------------------------------------------------------------------------
module psw_checker
    import psw_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t pilot_high_mean,
    input misfit_t pilot_high_misfits,
    input misfit_t pilot_low_misfits,
    input misfit_t proximity_misfits
);

    localparam misfit_t MIS_MAX = MISFIT_W'(WINDOW);

    // One burst at a time: input closes right after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pilot_high_mean))
        else $error("stalled result dropped or changed");

    a_misfit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pilot_high_misfits <= MIS_MAX) && (pilot_low_misfits <= MIS_MAX)
                      && (proximity_misfits <= MIS_MAX))
        else $error("misfit count exceeds window length");

    // A new result needs two ring passes, so no input transaction just before it
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared one cycle after input");

endmodule

bind pilot_signal_window_qualifier psw_checker #(.WINDOW(WINDOW)) u_psw_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .pilot_high_mean    (out_ch.pilot_high_mean),
    .pilot_high_misfits (out_ch.pilot_high_misfits),
    .pilot_low_misfits  (out_ch.pilot_low_misfits),
    .proximity_misfits  (out_ch.proximity_misfits)
);
